[hw/rtl/stc_pkg.sv]
package stc_pkg;

  // request kinds
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // control characters
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic [3:0] read_row;
    logic [4:0] read_col;
  } req_in_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [4:0] cursor_now;
    logic       pending_now;
  } res_out_t;

  // per-request status handed from the control unit to the output stage
  typedef struct packed {
    logic       hit;
    logic [4:0] cursor;
    logic       pending;
  } status_t;

  // memory strobes
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

[hw/rtl/stc_ram.sv]
module stc_ram #(
  parameter int DEPTH = 336,
  parameter int AW    = 9
) (
  input  logic          clk_i,
  input  stc_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/stc_ctrl.sv]
module stc_ctrl #(
  parameter int ROWS = 16,
  parameter int COLS = 21,
  parameter int AW   = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  stc_pkg::req_in_t   req_i,
  output stc_pkg::mem_ctl_t  mem_ctl_o,
  output logic [AW-1:0]      mem_addr_o,
  output logic [7:0]         mem_wdata_o,
  output stc_pkg::status_t   status_o
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS + 1);

  logic [RW-1:0] offset_q, offset_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic          pending_q, pending_d;
  // high-water mark per physical row: columns below it were written since the row was cleared
  logic [CW-1:0] fill_q [ROWS];

  logic          is_read;
  logic [31:0]   row_ext, col_ext;
  logic          in_screen;
  logic [RW:0]   rd_sum;
  logic [RW:0]   rd_wrap;
  logic [RW-1:0] rd_phys;
  logic [RW-1:0] bottom_row;
  logic [RW-1:0] base_row;
  logic [RW-1:0] fill_idx;
  logic [CW-1:0] fill_rd;
  logic [CW-1:0] fill0;
  logic [CW-1:0] cur0, cur1;
  logic [CW-1:0] wcol;
  logic [CW-1:0] wcol_inc;
  logic          we;
  logic          hit;
  logic [7:0]    wdata;
  logic          fill_we;
  logic [CW-1:0] fill_val;
  logic [31:0]   rd_addr, wr_addr;
  logic [31:0]   cursor_ext;

  assign is_read   = (req_i.req_type == stc_pkg::REQ_READ);
  assign row_ext   = 32'(req_i.read_row);
  assign col_ext   = 32'(req_i.read_col);
  assign in_screen = (row_ext < 32'(ROWS)) && (col_ext < 32'(COLS));

  // screen row to physical row: one compare and subtract
  assign rd_sum  = {1'b0, row_ext[RW-1:0]} + {1'b0, offset_q};
  assign rd_wrap = rd_sum - (RW+1)'(ROWS);
  assign rd_phys = (rd_sum >= (RW+1)'(ROWS)) ? rd_wrap[RW-1:0] : rd_sum[RW-1:0];

  assign bottom_row = (offset_q == '0) ? RW'(ROWS - 1) : offset_q - 1'b1;
  // a pending scroll makes the current top row the new bottom row
  assign base_row   = pending_q ? offset_q : bottom_row;

  assign fill_idx = is_read ? rd_phys : base_row;
  assign fill_rd  = fill_q[fill_idx];
  assign hit      = in_screen && (col_ext < 32'(fill_rd));

  assign fill0 = pending_q ? '0 : fill_rd;
  assign cur0  = pending_q ? '0 : cursor_q;
  assign cur1  = (cur0 != '0) ? cur0 - 1'b1 : '0;

  always_comb begin
    offset_d  = offset_q;
    cursor_d  = cursor_q;
    pending_d = pending_q;
    we        = 1'b0;
    wcol      = cur0;
    wdata     = req_i.char_code;
    fill_we   = 1'b0;
    fill_val  = fill0;
    if (fire_i && !is_read) begin
      if (pending_q) begin
        offset_d = (offset_q == RW'(ROWS - 1)) ? '0 : offset_q + 1'b1;
        fill_we  = 1'b1;
      end
      pending_d = 1'b0;
      cursor_d  = cur0;
      case (req_i.char_code)
        stc_pkg::CH_NEWLINE: begin
          pending_d = 1'b1;
          cursor_d  = '0;
        end
        stc_pkg::CH_BACKSPACE: begin
          cursor_d = cur1;
          if (32'(cur1) < 32'(COLS)) begin
            we    = 1'b1;
            wcol  = cur1;
            wdata = 8'd0;
          end
        end
        default: begin
          if (32'(cur0) < 32'(COLS)) begin
            we       = 1'b1;
            cursor_d = cur0 + 1'b1;
          end
        end
      endcase
      if (we) begin
        fill_we = 1'b1;
      end
    end
    wcol_inc = wcol + 1'b1;
    if (we && (wcol_inc > fill0)) begin
      fill_val = wcol_inc;
    end
  end

  assign rd_addr = 32'(rd_phys) * 32'(COLS) + col_ext;
  assign wr_addr = 32'(base_row) * 32'(COLS) + 32'(wcol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      cursor_q  <= '0;
      pending_q <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        fill_q[r] <= '0;
      end
    end else begin
      offset_q  <= offset_d;
      cursor_q  <= cursor_d;
      pending_q <= pending_d;
      if (fill_we) begin
        fill_q[base_row] <= fill_val;
      end
    end
  end

  assign cursor_ext = 32'(cursor_d);

  assign mem_ctl_o.we = we;
  assign mem_ctl_o.re = fire_i && is_read && hit;
  assign mem_addr_o   = we ? wr_addr[AW-1:0] : rd_addr[AW-1:0];
  assign mem_wdata_o  = wdata;

  assign status_o.hit     = is_read && hit;
  assign status_o.cursor  = cursor_ext[4:0];
  assign status_o.pending = pending_d;

endmodule

[hw/rtl/scrolling_text_console_buffer.sv]
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_ready_o    | in_req_i  (stc_pkg::req_in_t)
// out     | output    | out_valid_o / out_ready_i  | out_res_o (stc_pkg::res_out_t)
//
// One request per cycle unless the output stalls; its result shows in the cycle after acceptance.
// The single-port screen RAM does at most one access per request (a write for a put
// that stores a cell, a read for a hit), so the RAM port sets the one-per-cycle rate.
// Reset takes effect at once: per-row fill marks in flops blank the screen,
// no clearing pass. A scroll clears a row by zeroing its fill mark.
// A waiting result holds its stage; in_ready_o drops only while out_ready_i is low.
module scrolling_text_console_buffer #(
  parameter int ROWS = 16,
  parameter int COLS = 21
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stc_pkg::req_in_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stc_pkg::res_out_t  out_res_o
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              fire;
  stc_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]     mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;
  stc_pkg::status_t  status;

  // result stage
  logic              res_valid_q;
  stc_pkg::status_t  res_status_q;

  assign in_ready_o = !res_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // cursor, scroll ring and fill marks; decodes each request into at most one RAM access
  stc_ctrl #(
    .ROWS (ROWS),
    .COLS (COLS),
    .AW   (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .req_i       (in_req_i),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .status_o    (status)
  );

  // screen cells; read data only loads on an accepted read, so it holds during a stall
  stc_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      res_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_status_q <= status;
    end
  end

  // puts and misses answer blank
  assign out_valid_o           = res_valid_q;
  assign out_res_o.cell_char   = res_status_q.hit ? mem_rdata : 8'd0;
  assign out_res_o.cursor_now  = res_status_q.cursor;
  assign out_res_o.pending_now = res_status_q.pending;

`ifndef SYNTH
  // an accepted request always yields a result next cycle
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("accepted request produced no result");

  // a pending scroll always comes with a homed cursor
  a_pending_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.pending_now |-> out_res_o.cursor_now == 5'd0)
    else $error("pending scroll with cursor off home");

  // one RAM access per cycle, and only for an accepted request
  a_ram_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.we || mem_ctl.re) |-> fire && !(mem_ctl.we && mem_ctl.re))
    else $error("bad RAM access");

  // RAM accesses stay inside the screen
  a_ram_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.we || mem_ctl.re) |-> 32'(mem_addr) < 32'(DEPTH))
    else $error("RAM address beyond screen");
`endif

endmodule

[bench/tb_top.sv]
module tb_top;

  localparam int ROWS = 16;
  localparam int COLS = 21;

  // run bounds
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned BLOCKS          = 8;
  localparam int unsigned BLOCK_ITEMS     = 235;
  localparam int unsigned BURST_ITEMS     = 30;

  // traffic mixes: sender idle / receiver stall
  typedef enum int unsigned {
    MIX_STREAM,
    MIX_SENDER_IDLE,
    MIX_RECEIVER_STALL,
    MIX_BOTH
  } traffic_mix_e;

  // Tracks the expected screen contents, cursor and pending scroll, and
  // holds the results still to come back from the block, oldest first.
  class screen_tracker;
    logic [7:0]        cells [ROWS*COLS];
    int unsigned       top_row;
    int unsigned       cursor;
    bit                pend;
    stc_pkg::res_out_t awaited [$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       puts;
    int unsigned       reads;
    int unsigned       scrolls;
    int unsigned       drops;

    function new();
      foreach (cells[i]) cells[i] = 8'h00;
      top_row    = 0;
      cursor     = 0;
      pend       = 1'b0;
      mismatches = 0;
      checked    = 0;
      puts       = 0;
      reads      = 0;
      scrolls    = 0;
      drops      = 0;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    // apply one accepted request and queue the result it must produce
    function void note_request(stc_pkg::req_in_t r);
      stc_pkg::res_out_t e;
      int unsigned       bottom;
      e.cell_char = 8'h00;
      if (r.req_type == stc_pkg::REQ_READ) begin
        reads++;
        if (r.read_row < ROWS && r.read_col < COLS)
          e.cell_char = cells[((top_row + r.read_row) % ROWS) * COLS + r.read_col];
      end else begin
        puts++;
        // a waiting newline scrolls before any character is handled
        if (pend) begin
          for (int c = 0; c < COLS; c++) cells[top_row * COLS + c] = 8'h00;
          top_row = (top_row + 1) % ROWS;
          pend    = 1'b0;
          cursor  = 0;
          scrolls++;
        end
        bottom = ((top_row + ROWS - 1) % ROWS) * COLS;
        if (r.char_code == stc_pkg::CH_NEWLINE) begin
          pend   = 1'b1;
          cursor = 0;
        end else if (r.char_code == stc_pkg::CH_BACKSPACE) begin
          if (cursor > 0) cursor--;
          if (cursor < COLS) cells[bottom + cursor] = 8'h00;
        end else if (cursor < COLS) begin
          cells[bottom + cursor] = r.char_code;
          cursor++;
        end else begin
          drops++;
        end
      end
      e.cursor_now  = 5'(cursor);
      e.pending_now = pend;
      awaited.push_back(e);
    endfunction

    task report_mismatch(string field, int unsigned got_v, int unsigned want_v);
      mismatches++;
      $display("mismatch on result %0d, %s: got %0d, expected %0d",
               checked, field, got_v, want_v);
    endtask

    task check_result(stc_pkg::res_out_t got);
      stc_pkg::res_out_t e;
      if (awaited.size() == 0) begin
        report_mismatch("result with no request waiting", got, 0);
        return;
      end
      e = awaited.pop_front();
      if (got.cell_char != e.cell_char)
        report_mismatch("cell_char", got.cell_char, e.cell_char);
      if (got.cursor_now != e.cursor_now)
        report_mismatch("cursor_now", got.cursor_now, e.cursor_now);
      if (got.pending_now != e.pending_now)
        report_mismatch("pending_now", got.pending_now, e.pending_now);
      checked++;
    endtask
  endclass

  // every block input has a known value from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  stc_pkg::req_in_t  in_req_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  stc_pkg::res_out_t out_res_o;

  screen_tracker tracker;

  int unsigned idle_pct      = 0;
  int unsigned stall_pct     = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_off_seq  = 0;   // bumped by the stimulus to ask for a long hold-off
  int unsigned hold_off_seen = 0;
  int unsigned hold_left     = 0;
  int unsigned line_left     = 0;   // characters left in the current random line

  scrolling_text_console_buffer #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, tracker.outstanding());
      $display("Some tests failed");
      $finish;
    end
  end

  // Monitors sample pre-edge values, so a request accepted at an edge is
  // always noted before its result, which can only be taken at a later edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) tracker.note_request(in_req_i);
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_result(out_res_o);
  end

  // Receiver. A requested hold-off keeps ready low until its hold counter,
  // loaded from HOLD_OFF_CYCLES, runs out; otherwise ready drops at random per the current mix.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_off_seen != hold_off_seq) begin
      hold_off_seen <= hold_off_seq;
      hold_left     <= HOLD_OFF_CYCLES;
      out_ready_i   <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task set_mix(traffic_mix_e mix);
    case (mix)
      MIX_STREAM: begin
        idle_pct  = 0;
        stall_pct <= 0;
      end
      MIX_SENDER_IDLE: begin
        idle_pct  = 48;
        stall_pct <= 0;
      end
      MIX_RECEIVER_STALL: begin
        idle_pct  = 0;
        stall_pct <= 48;
      end
      default: begin
        idle_pct  = 15;
        stall_pct <= 15;
      end
    endcase
  endtask

  // Offer one request and return at the edge where it is taken. Each cycle
  // before the offer is idle with the mix's odds, valid low; otherwise valid
  // stays high and only the payload moves on to the next request.
  task send_request(stc_pkg::req_in_t r);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sender pauses until every queued result has come back.
  task drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic stc_pkg::req_in_t make_put(logic [7:0] ch);
    stc_pkg::req_in_t r;
    r.req_type  = stc_pkg::REQ_PUT;
    r.char_code = ch;
    r.read_row  = 4'($urandom_range(0, 15));   // ignored on a put
    r.read_col  = 5'($urandom_range(0, 31));
    return r;
  endfunction

  function automatic stc_pkg::req_in_t make_read(int unsigned row, int unsigned col);
    stc_pkg::req_in_t r;
    r.req_type  = stc_pkg::REQ_READ;
    r.char_code = 8'($urandom_range(0, 255));  // ignored on a read
    r.read_row  = 4'(row);
    r.read_col  = 5'(col);
    return r;
  endfunction

  // Mostly well-formed text: lines of random length (some past the right
  // edge) with stray backspaces, closed by a newline, and reads spread over
  // the screen. About one request in ten is raw noise in every field.
  function automatic stc_pkg::req_in_t random_request();
    stc_pkg::req_in_t r;
    int unsigned      pick;
    r.req_type  = stc_pkg::REQ_PUT;
    r.char_code = 8'($urandom_range(0, 255));
    r.read_row  = 4'($urandom_range(0, 15));
    r.read_col  = 5'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.req_type = 1'($urandom_range(0, 1));
    end else if (pick < 38) begin
      r.req_type = stc_pkg::REQ_READ;
      // most reads land on the screen; the rest take any column and may fall past the last one
      if ($urandom_range(0, 99) < 88) r.read_col = 5'($urandom_range(0, COLS - 1));
    end else if (line_left == 0) begin
      r.char_code = stc_pkg::CH_NEWLINE;
      line_left   = $urandom_range(0, COLS + 6);
    end else begin
      line_left--;
      if ($urandom_range(0, 99) < 10)
        r.char_code = stc_pkg::CH_BACKSPACE;
      else if (r.char_code == stc_pkg::CH_NEWLINE || r.char_code == stc_pkg::CH_BACKSPACE)
        r.char_code = 8'h2e;
    end
    return r;
  endfunction

  initial begin
    tracker = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, streaming with no gaps.
    set_mix(MIX_STREAM);
    send_request(make_read(0, 0));                       // blank after reset
    send_request(make_put(stc_pkg::CH_BACKSPACE));       // backspace at column 0
    send_request(make_put(8'hff));
    send_request(make_put(8'h00));                       // code 0 stored, reads as blank
    send_request(make_put(stc_pkg::CH_BACKSPACE));
    send_request(make_put(stc_pkg::CH_NEWLINE));         // newline with nothing pending
    send_request(make_put(stc_pkg::CH_NEWLINE));         // scrolls, then pends again
    send_request(make_put(stc_pkg::CH_BACKSPACE));       // scroll first, then clears cell 0
    send_request(make_put(stc_pkg::CH_NEWLINE));
    send_request(make_put(8'h41));                       // scroll then write
    // run the bottom line to the right edge; the last two are dropped
    for (int k = 0; k < COLS + 1; k++) send_request(make_put(8'(8'h42 + k)));
    send_request(make_read(ROWS - 1, COLS - 1));
    send_request(make_read(ROWS - 1, 31));               // past the last column
    send_request(make_read(ROWS - 4, 0));                // older line, scrolled up
    drain();

    // Random part, cycling through the traffic mixes.
    for (int b = 0; b < BLOCKS; b++) begin
      set_mix(traffic_mix_e'(b % 4));
      for (int k = 0; k < BLOCK_ITEMS; k++) send_request(random_request());
      if (b == 3) begin
        // long receiver hold-off while requests keep coming: the block
        // fills and has to back-pressure its input
        set_mix(MIX_STREAM);
        hold_off_seq <= hold_off_seq + 1;
        for (int k = 0; k < BURST_ITEMS; k++) send_request(random_request());
      end
      if (b % 2 == 1) drain();
    end

    drain();
    repeat (10) @(posedge clk_i);

    $display("covered %0d requests (%0d puts, %0d reads), %0d results checked",
             tracker.puts + tracker.reads, tracker.puts, tracker.reads, tracker.checked);
    $display("%0d scrolls, %0d characters dropped on full lines, four traffic mixes",
             tracker.scrolls, tracker.drops);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[scrolling_text_console_buffer.f]
hw/rtl/stc_pkg.sv
hw/rtl/stc_ram.sv
hw/rtl/stc_ctrl.sv
hw/rtl/scrolling_text_console_buffer.sv
bench/tb_top.sv
